// ===== rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rpa_pkg.sv =====
package rpa_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [12:0] temperature;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  heater_power;
        logic [2:0]  status;
        logic        cycle_report;
        logic [7:0]  bias_out;
        logic [7:0]  swing_out;
        logic [12:0] peak_high;
        logic [12:0] peak_low;
        logic [20:0] high_time_ms;
        logic [20:0] low_time_ms;
        logic [6:0]  cycle_count;
    } out_item_t;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RUNNING  = 3'd1;
    localparam logic [2:0] ST_FINISHED = 3'd2;
    localparam logic [2:0] ST_TOO_HOT  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_CYCLES = 2'd1;
    localparam logic [1:0] REG_BED    = 2'd2;

    localparam logic [31:0] PHASE_MIN_MS = 32'd5000;
    localparam logic [8:0]  BIAS_MARGIN  = 9'd20;
    localparam logic [13:0] OVERHEAT_Q4  = 14'd800;
    localparam logic [32:0] TIMEOUT_MS   = 33'd1200000;
    localparam logic [12:0] TEMP_TOP     = 13'd8191;
    localparam logic [31:0] TIME_TOP     = 32'd2097151;
    localparam logic [6:0]  CYCLE_TOP    = 7'd127;

    typedef enum logic [1:0] {
        C_IDLE,
        C_STEP,
        C_DIV,
        C_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } stat_t;

endpackage

// ===== rtl/relay_pid_autotune.sv =====
// Relay-feedback heater autotune.
// Input channel s_*: one transaction per start, sample, tick or nop item (s_item).
// Result channel m_*: exactly one result transaction per input transaction.
// Configuration channel cfg_*: index 0 target, 1 cycle limit, 2 bed select;
//   write only while the block is idle.
// Sequencing: an item is latched, stepped in C_STEP and presented in C_OUT; a sample
//   that closes a cooling phase other than the first also runs the 29-step
//   shift-subtract divider (C_DIV) before C_OUT. One item is in flight at a time: no
//   new item is taken until the result of the last one has been taken.
// The result is held in an output register; while the receiver stalls the
//   result stays valid and unchanged and no new item is taken.
// Reset (aresetn low, synchronous) returns the tuner to idle with the
//   power-on register values; no clearing pass is needed.
module relay_pid_autotune #(
    parameter int HOTEND_POWER_MAX = 255,
    parameter int BED_POWER_MAX = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpa_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rpa_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);
    rpa_pkg::cmd_t  cmd;
    rpa_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    rpa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_valid && s_ready), .out_fire(m_valid && m_ready),
        .stat(stat), .cmd(cmd), .in_ready(s_ready), .out_valid(m_valid)
    );

    rpa_datapath #(
        .HOTEND_POWER_MAX(HOTEND_POWER_MAX), .BED_POWER_MAX(BED_POWER_MAX)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_item), .cmd(cmd),
        .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .stat(stat), .out_item(m_item)
    );
endmodule

// ===== rtl/rpa_ctrl.sv =====
module rpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              out_fire,
    input  rpa_pkg::stat_t    stat,
    output rpa_pkg::cmd_t     cmd,
    output logic              in_ready,
    output logic              out_valid
);
    rpa_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpa_pkg::C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpa_pkg::C_IDLE: if (in_fire) state_next = rpa_pkg::C_STEP;
            rpa_pkg::C_STEP: state_next = stat.need_div ? rpa_pkg::C_DIV : rpa_pkg::C_OUT;
            rpa_pkg::C_DIV:  if (stat.div_done) state_next = rpa_pkg::C_OUT;
            rpa_pkg::C_OUT:  if (out_fire) state_next = rpa_pkg::C_IDLE;
            default:         state_next = rpa_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            rpa_pkg::C_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            rpa_pkg::C_STEP: cmd.div_start = stat.need_div;
            rpa_pkg::C_DIV:  cmd.finish = stat.div_done;
            rpa_pkg::C_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== rtl/rpa_datapath.sv =====
module rpa_datapath #(
    parameter int HOTEND_POWER_MAX = 255,
    parameter int BED_POWER_MAX = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rpa_pkg::in_item_t  in_item,
    input  rpa_pkg::cmd_t      cmd,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [12:0]        cfg_data,
    output rpa_pkg::stat_t     stat,
    output rpa_pkg::out_item_t out_item
);
    localparam logic [8:0] HMAX = 9'(HOTEND_POWER_MAX);
    localparam logic [8:0] BMAX = 9'(BED_POWER_MAX);

    logic [12:0] target_reg;
    logic [6:0]  limit_reg;
    logic        bed_reg;
    logic        running_reg, heating_reg, report_reg;
    logic [6:0]  cycles_reg;
    logic [31:0] cool_reg, heat_reg;
    logic [20:0] high_reg, low_reg;
    logic [7:0]  bias_reg, swing_reg, drive_reg;
    logic [12:0] max_reg, min_reg, last_reg;
    logic [2:0]  status_reg;
    rpa_pkg::in_item_t item_reg;

    logic [8:0] pm;
    assign pm = bed_reg ? BMAX : HMAX;

    // combinational step on the latched item, adaptation excluded
    logic        n_heating, n_adapt;
    logic [6:0]  n_cycles;
    logic [31:0] n_cool, n_heat, d_heat;
    logic [20:0] n_high, n_low;
    logic [12:0] n_max, n_min, n_last;
    logic [7:0]  n_drive;

    always_comb begin
        n_heating = heating_reg;
        n_adapt = 1'b0;
        n_cycles = cycles_reg;
        n_cool = cool_reg;
        n_heat = heat_reg;
        n_high = high_reg;
        n_low = low_reg;
        n_max = max_reg;
        n_min = min_reg;
        n_last = last_reg;
        n_drive = drive_reg;
        d_heat = item_reg.now_ms - heat_reg;
        if (item_reg.op == rpa_pkg::OP_SAMPLE) begin
            n_last = item_reg.temperature;
            if (item_reg.temperature > max_reg) n_max = item_reg.temperature;
            if (item_reg.temperature < min_reg) n_min = item_reg.temperature;
            if (heating_reg && item_reg.temperature > target_reg
                    && d_heat > rpa_pkg::PHASE_MIN_MS) begin
                n_heating = 1'b0;
                n_drive = (bias_reg > swing_reg) ? 8'((bias_reg - swing_reg) >> 1) : 8'd0;
                n_cool = item_reg.now_ms;
                n_high = (d_heat > rpa_pkg::TIME_TOP) ? 21'(rpa_pkg::TIME_TOP) : d_heat[20:0];
                n_max = target_reg;
            end
            if (!n_heating && item_reg.temperature < target_reg
                    && (item_reg.now_ms - n_cool) > rpa_pkg::PHASE_MIN_MS) begin
                n_heating = 1'b1;
                n_heat = item_reg.now_ms;
                n_low = ((item_reg.now_ms - n_cool) > rpa_pkg::TIME_TOP)
                      ? 21'(rpa_pkg::TIME_TOP) : 21'(item_reg.now_ms - n_cool);
                n_adapt = (cycles_reg != 7'd0);
                n_drive = 8'((9'(bias_reg) + 9'(swing_reg)) >> 1);
                if (cycles_reg < rpa_pkg::CYCLE_TOP) n_cycles = cycles_reg + 7'd1;
                n_min = target_reg;
            end
        end
    end

    // restoring divider on magnitudes
    logic [28:0] num_reg;
    logic [21:0] den_reg, rem_reg;
    logic [28:0] quo_reg;
    logic        neg_reg, div_busy_reg;
    logic [4:0]  div_cnt_reg;
    logic [22:0] trial;
    assign trial = {rem_reg, num_reg[28]} - {1'b0, den_reg};

    logic [21:0] diff_mag;
    logic        diff_neg;
    assign diff_neg = n_low > n_high;
    assign diff_mag = diff_neg ? 22'(n_low - n_high) : 22'(n_high - n_low);

    assign stat.need_div = running_reg && item_reg.op != rpa_pkg::OP_START
                        && item_reg.op != rpa_pkg::OP_NOP && n_adapt;
    assign stat.div_done = div_busy_reg && div_cnt_reg == 5'd0;

    // adapted bias from the quotient (|q| < 512 used directly, larger saturates)
    logic signed [10:0] b_new;
    logic [8:0] b_cl;
    always_comb begin
        b_new = neg_reg ? 11'(signed'({3'b0, bias_reg}) - signed'({2'b0, quo_reg[8:0]}))
                        : 11'(signed'({3'b0, bias_reg}) + signed'({2'b0, quo_reg[8:0]}));
        if (quo_reg[28:9] != '0) b_new = neg_reg ? -11'sd512 : 11'sd511;
        if (b_new > signed'({2'b0, pm - rpa_pkg::BIAS_MARGIN}))
            b_new = signed'({2'b0, pm - rpa_pkg::BIAS_MARGIN});
        if (b_new < signed'({2'b0, rpa_pkg::BIAS_MARGIN}))
            b_new = signed'({2'b0, rpa_pkg::BIAS_MARGIN});
        b_cl = b_new[8:0];
    end
    logic [7:0] s_new;
    assign s_new = (b_cl > {1'b0, pm[8:1]}) ? 8'(pm - 9'd1 - b_cl) : b_cl[7:0];

    logic [31:0] e_cool, e_heat;
    logic [32:0] elapsed;
    logic [2:0]  end_code;
    always_comb begin
        e_cool = item_reg.now_ms - n_cool;
        e_heat = item_reg.now_ms - n_heat;
        elapsed = {1'b0, e_cool} + {1'b0, e_heat};
        end_code = rpa_pkg::ST_RUNNING;
        if (14'(n_last) > 14'(target_reg) + rpa_pkg::OVERHEAT_Q4) end_code = rpa_pkg::ST_TOO_HOT;
        else if (elapsed > rpa_pkg::TIMEOUT_MS) end_code = rpa_pkg::ST_TIMEOUT;
        else if (n_cycles > limit_reg || n_cycles >= rpa_pkg::CYCLE_TOP)
            end_code = rpa_pkg::ST_FINISHED;
    end

    logic step_cyc_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 13'd2400; limit_reg <= 7'd5; bed_reg <= 1'b0;
            running_reg <= 1'b0; heating_reg <= 1'b1; cycles_reg <= '0;
            cool_reg <= '0; heat_reg <= '0; high_reg <= '0; low_reg <= '0;
            bias_reg <= '0; swing_reg <= '0; max_reg <= '0; min_reg <= rpa_pkg::TEMP_TOP;
            last_reg <= '0; drive_reg <= '0; status_reg <= rpa_pkg::ST_IDLE;
            report_reg <= 1'b0; div_busy_reg <= 1'b0; step_cyc_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            step_cyc_reg <= cmd.load;
            if (cfg_we) begin
                unique case (cfg_idx)
                    rpa_pkg::REG_TARGET: target_reg <= cfg_data;
                    rpa_pkg::REG_CYCLES: limit_reg <= cfg_data[6:0];
                    rpa_pkg::REG_BED:    bed_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                item_reg <= in_item;
                report_reg <= 1'b0;
            end
            if (step_cyc_reg) begin
                if (item_reg.op == rpa_pkg::OP_START) begin
                    running_reg <= 1'b1; heating_reg <= 1'b1; status_reg <= rpa_pkg::ST_RUNNING;
                    cycles_reg <= '0; cool_reg <= item_reg.now_ms; heat_reg <= item_reg.now_ms;
                    high_reg <= '0; low_reg <= '0; max_reg <= '0;
                    min_reg <= rpa_pkg::TEMP_TOP; last_reg <= '0;
                    bias_reg <= pm[8:1]; swing_reg <= pm[8:1]; drive_reg <= pm[8:1];
                end else if (running_reg && item_reg.op != rpa_pkg::OP_NOP) begin
                    heating_reg <= n_heating; cycles_reg <= n_cycles;
                    cool_reg <= n_cool; heat_reg <= n_heat;
                    high_reg <= n_high; low_reg <= n_low;
                    max_reg <= n_max; min_reg <= n_min; last_reg <= n_last;
                    drive_reg <= n_drive; status_reg <= end_code;
                    running_reg <= (end_code == rpa_pkg::ST_RUNNING);
                end
            end
            if (cmd.div_start) begin
                num_reg <= 29'(diff_mag) * 29'(swing_reg);
                den_reg <= 22'(n_high) + 22'(n_low);
                neg_reg <= diff_neg;
                rem_reg <= '0;
                quo_reg <= '0;
                div_cnt_reg <= 5'd29;
                div_busy_reg <= 1'b1;
            end else if (div_busy_reg && div_cnt_reg != 5'd0) begin
                num_reg <= {num_reg[27:0], 1'b0};
                if (!trial[22]) begin
                    rem_reg <= trial[21:0];
                    quo_reg <= {quo_reg[27:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[20:0], num_reg[28]};
                    quo_reg <= {quo_reg[27:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            if (cmd.finish) begin
                div_busy_reg <= 1'b0;
                report_reg <= 1'b1;
                if (den_reg == '0) begin
                    quo_reg <= '0;
                end
                bias_reg <= (den_reg == '0) ? bias_reg : b_cl[7:0];
                swing_reg <= s_new;
                drive_reg <= 8'((9'(b_cl[7:0]) + 9'(s_new)) >> 1);
            end
        end
    end

    assign out_item.heater_power = drive_reg;
    assign out_item.status = status_reg;
    assign out_item.cycle_report = report_reg;
    assign out_item.bias_out = bias_reg;
    assign out_item.swing_out = swing_reg;
    assign out_item.peak_high = max_reg;
    assign out_item.peak_low = min_reg;
    assign out_item.high_time_ms = high_reg;
    assign out_item.low_time_ms = low_reg;
    assign out_item.cycle_count = cycles_reg;
endmodule

// ===== rtl/rpa_checker.sv =====
`include "assert_macros.svh"
module rpa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rpa_pkg::out_item_t m_item
);
    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, (m_valid |-> !s_ready), "input taken while result pending")
    `ASSERT_CLK(a_hold, aclk, aresetn, (m_valid && !m_ready |=> $stable(m_item)), "stalled result changed")
    `ASSERT_CLK(a_status, aclk, aresetn, (m_valid |-> m_item.status <= rpa_pkg::ST_TIMEOUT), "bad status")
    `ASSERT_ALWAYS(a_reset, aclk, (!aresetn |=> !m_valid), "result valid after reset")
endmodule

bind relay_pid_autotune rpa_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);
